/* sv/gbti_pkg.sv */
// ----------------------------------------------------------------------------
// gbti_pkg: shared types and constants
// Field widths, word layouts and triangle slot codes for the terrain grid
// triangle index unit.
// ----------------------------------------------------------------------------
package gbti_pkg;

    // Field widths.
    localparam int BLOCK_W = 14;
    localparam int CFG_W   = 8;
    localparam int HALF_W  = CFG_W - 1;
    localparam int VTX_W   = 16;
    localparam int SLOT_W  = 4;

    // Default grid size after reset.
    localparam logic [CFG_W-1:0] CELLS_RESET = CFG_W'(16);

    // Triangle slots of one block: four for the upper cell pair, four for the
    // lower pair and one for the padding triangle.
    localparam logic [SLOT_W-1:0] SLOT_FIRST     = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_TOP_LAST  = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_UPPER_END = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_LOWER     = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_LOWER_END = SLOT_W'(7);
    localparam logic [SLOT_W-1:0] SLOT_PAD       = SLOT_W'(8);

    // Quotient and remainder of the block index over blocks per side.
    typedef struct packed {
        logic [BLOCK_W-1:0] quo;
        logic [HALF_W-1:0]  rem;
        logic               gaps;
        logic               pad;
    } gbti_div_t;

    // Base vertices and cell flags of one block.
    typedef struct packed {
        logic [VTX_W-1:0] v0;
        logic [VTX_W-1:0] vl;
        logic [VTX_W-1:0] w;
        logic             top;
        logic             gap_u;
        logic             gap_l;
        logic             pad;
    } gbti_base_t;

    // Vertex offset from a cell base: optional row width plus a small step.
    typedef struct packed {
        logic       use_w;
        logic [1:0] k;
    } gbti_off_t;

endpackage

/* sv/gbti_div.sv */
// ----------------------------------------------------------------------------
// gbti_div: pipelined block index divider
// Restoring division of the block index by the blocks per side, one quotient
// bit per register stage, with valid bits travelling alongside the data.
// ----------------------------------------------------------------------------
module gbti_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gbti_pkg::BLOCK_W-1:0]  in_block,
    input  logic                          in_gaps,
    input  logic                          in_pad,
    input  logic [gbti_pkg::HALF_W-1:0]   half,
    output logic                          out_valid,
    output gbti_pkg::gbti_div_t           out_item
);

    localparam int STEPS = gbti_pkg::BLOCK_W;

    logic                valid_reg [0:STEPS];
    gbti_pkg::gbti_div_t stage_reg [0:STEPS];

    // Input capture stage: the quotient field starts out as the dividend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0].quo  <= in_block;
            stage_reg[0].rem  <= '0;
            stage_reg[0].gaps <= in_gaps;
            stage_reg[0].pad  <= in_pad;
        end
    end

    // One compare and subtract per stage; quotient bits shift in from below.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [gbti_pkg::HALF_W:0] partial;
        logic [gbti_pkg::HALF_W:0] diff;
        logic                      ge;

        assign partial = {stage_reg[i].rem, stage_reg[i].quo[STEPS-1]};
        assign diff    = partial - {1'b0, half};
        assign ge      = partial >= {1'b0, half};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[i+1].quo  <= {stage_reg[i].quo[STEPS-2:0], ge};
                stage_reg[i+1].rem  <= ge ? diff[gbti_pkg::HALF_W-1:0]
                                          : partial[gbti_pkg::HALF_W-1:0];
                stage_reg[i+1].gaps <= stage_reg[i].gaps;
                stage_reg[i+1].pad  <= stage_reg[i].pad;
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_item  = stage_reg[STEPS];

endmodule

/* sv/gbti_vtx.sv */
// ----------------------------------------------------------------------------
// gbti_vtx: block base vertex stages
// Two register stages: the block row times the doubled row width, then the
// base vertices of the upper and lower cell pairs and the cell flags.
// ----------------------------------------------------------------------------
module gbti_vtx
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  gbti_pkg::gbti_div_t          in_item,
    input  logic [gbti_pkg::CFG_W-1:0]   cells,
    input  logic [gbti_pkg::HALF_W-1:0]  half,
    output logic                         out_valid,
    output gbti_pkg::gbti_base_t         out_item
);

    localparam int PROD_W = gbti_pkg::BLOCK_W + gbti_pkg::CFG_W + 1;

    logic [gbti_pkg::CFG_W:0]    step;
    logic [PROD_W-1:0]           prod_full;
    logic [gbti_pkg::BLOCK_W-1:0] half_q;

    logic                        mul_valid_reg;
    logic [gbti_pkg::VTX_W-1:0]  prod_reg;
    logic [gbti_pkg::HALF_W-1:0] rem_reg;
    logic                        top_reg;
    logic                        gap_u_reg;
    logic                        gap_l_reg;
    logic                        pad_reg;

    logic                        base_valid_reg;
    gbti_pkg::gbti_base_t        base_reg;
    logic [gbti_pkg::VTX_W-1:0]  v0_next;
    logic [gbti_pkg::VTX_W-1:0]  w_next;

    // Two block rows of vertices: 2 * (cells + 1).
    assign step      = {cells, 1'b0} + (gbti_pkg::CFG_W + 1)'(2);
    assign prod_full = PROD_W'(in_item.quo) * PROD_W'(step);
    assign half_q    = gbti_pkg::BLOCK_W'(half);

    // Multiply stage, with the row tests on the block row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_full[gbti_pkg::VTX_W-1:0];
            rem_reg   <= in_item.rem;
            top_reg   <= in_item.quo == '0;
            // Upper pair lies in the bottom row only when the block is past it.
            gap_u_reg <= in_item.gaps && (in_item.quo >= half_q);
            gap_l_reg <= in_item.gaps && (in_item.quo >= half_q - 1'b1);
            pad_reg   <= in_item.pad;
        end
    end

    // Base vertex stage.
    assign v0_next = prod_reg + gbti_pkg::VTX_W'({rem_reg, 1'b0});
    assign w_next  = gbti_pkg::VTX_W'(cells) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            base_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg.v0    <= v0_next;
            base_reg.vl    <= v0_next + w_next;
            base_reg.w     <= w_next;
            base_reg.top   <= top_reg;
            base_reg.gap_u <= gap_u_reg;
            base_reg.gap_l <= gap_l_reg;
            base_reg.pad   <= pad_reg;
        end
    end

    assign out_valid = base_valid_reg;
    assign out_item  = base_reg;

endmodule

/* sv/gbti_emit.sv */
// ----------------------------------------------------------------------------
// gbti_emit: triangle sequencer and output register
// Holds one block, walks its triangle slots one per cycle unless the output
// stalls, and drives the output word through a register that decouples it from the pipeline.
// ----------------------------------------------------------------------------
module gbti_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  gbti_pkg::gbti_base_t        in_item,
    output logic                        in_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [3*gbti_pkg::VTX_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int VW = gbti_pkg::VTX_W;

    logic                        item_valid_reg;
    logic [gbti_pkg::SLOT_W-1:0] slot_reg;
    gbti_pkg::gbti_base_t        item_reg;

    logic                        m_tvalid_reg;
    logic [3*VW-1:0]             m_tdata_reg;
    logic                        m_tlast_reg;

    logic                        out_en;
    logic                        fire;
    logic                        is_last;
    logic                        lower;
    logic                        zero_tri;
    logic [VW-1:0]               base;
    gbti_pkg::gbti_off_t         off_a;
    gbti_pkg::gbti_off_t         off_b;
    gbti_pkg::gbti_off_t         off_c;
    logic [VW-1:0]               vtx_a;
    logic [VW-1:0]               vtx_b;
    logic [VW-1:0]               vtx_c;

    // Vertex of a triangle from its cell base and offset.
    function automatic logic [VW-1:0] vtx_at(input logic [VW-1:0] b,
                                             input logic [VW-1:0] w,
                                             input gbti_pkg::gbti_off_t o);
        logic [VW-1:0] row;
        row = o.use_w ? w : '0;
        return b + row + VW'(o.k);
    endfunction

    // Handshake bookkeeping.
    assign out_en   = !m_tvalid_reg || m_tready;
    assign fire     = item_valid_reg && out_en;
    assign is_last  = (slot_reg == gbti_pkg::SLOT_PAD) ||
                      ((slot_reg == gbti_pkg::SLOT_LOWER_END) && !item_reg.pad);
    assign in_ready = !item_valid_reg || (fire && is_last);

    // Triangle shape of the current slot.
    assign lower    = slot_reg[2];
    assign base     = lower ? item_reg.vl : item_reg.v0;
    assign zero_tri = (slot_reg == gbti_pkg::SLOT_PAD) ||
                      (lower ? item_reg.gap_l : item_reg.gap_u);

    always_comb
    begin
        off_a = '{use_w: 1'b0, k: 2'd0};
        off_b = '{use_w: 1'b0, k: 2'd0};
        off_c = '{use_w: 1'b0, k: 2'd0};
        if (!lower && item_reg.top)
        begin
            // Top grid row, stitched to the coarser neighbour.
            case (slot_reg[1:0])
                2'd0:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd0};
                    off_b = '{use_w: 1'b0, k: 2'd2};
                    off_c = '{use_w: 1'b1, k: 2'd1};
                end
                2'd1:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd0};
                    off_b = '{use_w: 1'b1, k: 2'd0};
                    off_c = '{use_w: 1'b1, k: 2'd1};
                end
                default:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd2};
                    off_b = '{use_w: 1'b1, k: 2'd1};
                    off_c = '{use_w: 1'b1, k: 2'd2};
                end
            endcase
        end
        else
        begin
            // Two triangles per cell, left cell first.
            case (slot_reg[1:0])
                2'd0:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd0};
                    off_b = '{use_w: 1'b0, k: 2'd1};
                    off_c = '{use_w: 1'b1, k: 2'd0};
                end
                2'd1:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd1};
                    off_b = '{use_w: 1'b1, k: 2'd0};
                    off_c = '{use_w: 1'b1, k: 2'd1};
                end
                2'd2:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd1};
                    off_b = '{use_w: 1'b0, k: 2'd2};
                    off_c = '{use_w: 1'b1, k: 2'd1};
                end
                default:
                begin
                    off_a = '{use_w: 1'b0, k: 2'd2};
                    off_b = '{use_w: 1'b1, k: 2'd1};
                    off_c = '{use_w: 1'b1, k: 2'd2};
                end
            endcase
        end
    end

    assign vtx_a = zero_tri ? '0 : vtx_at(base, item_reg.w, off_a);
    assign vtx_b = zero_tri ? '0 : vtx_at(base, item_reg.w, off_b);
    assign vtx_c = zero_tri ? '0 : vtx_at(base, item_reg.w, off_c);

    // Slot sequencer; the top row has only three upper triangles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            slot_reg       <= gbti_pkg::SLOT_FIRST;
        end
        else if (in_ready && in_valid)
        begin
            item_valid_reg <= 1'b1;
            slot_reg       <= gbti_pkg::SLOT_FIRST;
        end
        else if (fire && is_last)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            if ((slot_reg == gbti_pkg::SLOT_TOP_LAST) && item_reg.top)
            begin
                slot_reg <= gbti_pkg::SLOT_LOWER;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            m_tvalid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_tdata_reg <= {vtx_c, vtx_b, vtx_a};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A stitched top row never reaches the fourth upper slot.
    a_top_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && item_reg.top) |-> (slot_reg != gbti_pkg::SLOT_UPPER_END))
        else $error("top row block reached the fourth upper slot");

    // The padding slot is only reached when padding was asked for.
    a_pad_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && (slot_reg == gbti_pkg::SLOT_PAD)) |-> item_reg.pad)
        else $error("padding slot without padding");

    // The slot counter stays within the block's triangle list.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (slot_reg <= gbti_pkg::SLOT_PAD))
        else $error("slot counter out of range");

    // After the last triangle the sequencer is empty or starts a new block.
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last) |=> (!item_valid_reg || (slot_reg == gbti_pkg::SLOT_FIRST)))
        else $error("sequencer did not restart after the last triangle");

endmodule

/* sv/grid_block_triangle_indices_unit.sv */
// ----------------------------------------------------------------------------
// grid_block_triangle_indices_unit: terrain grid triangle index generator
// Turns the index of one 2x2 cell block into the vertex index triangles of
// its four cells, with top-row stitching, bottom-row gaps and padding.
// ----------------------------------------------------------------------------
// Each block word yields seven to nine triangle words (eight for an ordinary
// block without padding), one per cycle unless the output stalls; a new block
// is taken only when the sequencer is empty or emits its last triangle. The
// front end is a pipeline that takes a word in every cycle unless stalled:
// fifteen divider stages resolve the block row and column, one stage multiplies
// out the block row and one forms the base vertices; the sequencer's block
// register and the output register come after. A stalled output holds the
// whole pipeline without losing a word. The grid size register is to be
// written by the user only while the unit is idle; the unit does not enforce
// this. Its low bit is ignored and values below two act as two.
// ----------------------------------------------------------------------------
module grid_block_triangle_indices_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: cells per grid side.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    // Block input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] block_index, [15:14] zero
    input  logic [1:0]  s_tuser,   // [0] gap_bottom_row, [1] pad_with_empty
    // Triangle output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c
    output logic        m_tlast    // last_triangle
);

    logic [gbti_pkg::CFG_W-1:0]  cells_per_side_reg;
    logic [gbti_pkg::CFG_W-1:0]  cells;
    logic [gbti_pkg::HALF_W-1:0] half;

    logic                        en;
    logic                        div_valid;
    gbti_pkg::gbti_div_t         div_item;
    logic                        base_valid;
    gbti_pkg::gbti_base_t        base_item;
    logic                        emit_ready;

    // Grid size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_per_side_reg <= gbti_pkg::CELLS_RESET;
        end
        else if (cfg_we)
        begin
            cells_per_side_reg <= cfg_data;
        end
    end

    // Effective cell count: even and at least two.
    assign half  = (cells_per_side_reg[gbti_pkg::CFG_W-1:1] == '0)
                   ? gbti_pkg::HALF_W'(1) : cells_per_side_reg[gbti_pkg::CFG_W-1:1];
    assign cells = {half, 1'b0};

    // The pipeline moves unless a finished block waits for the sequencer.
    assign en       = emit_ready || !base_valid;
    assign s_tready = en;

    gbti_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_block  (s_tdata[gbti_pkg::BLOCK_W-1:0]),
        .in_gaps   (s_tuser[0]),
        .in_pad    (s_tuser[1]),
        .half      (half),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    gbti_vtx u_vtx
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .cells     (cells),
        .half      (half),
        .out_valid (base_valid),
        .out_item  (base_item)
    );

    gbti_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (base_valid),
        .in_item   (base_item),
        .in_ready  (emit_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
